>>> src/rgwa_pkg.sv
// ----------------------------------------------------------------------------
// rgwa_pkg
// Shared types and codes for the right-linear grammar word acceptor.
// ----------------------------------------------------------------------------
package rgwa_pkg;

	localparam int NUM_NONTERMINALS_DEF = 16;
	localparam int MAX_PRODUCTIONS_DEF  = 8;

	// width used for index range checks; holds any nonterminal count up to 127
	localparam int IDX_CMP_W = 7;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;
	localparam logic [1:0] ACT_FEED  = 2'd3;

	localparam logic [1:0] KIND_NEXT   = 2'd0;
	localparam logic [1:0] KIND_TERM   = 2'd1;
	localparam logic [1:0] KIND_LAMBDA = 2'd2;
	localparam logic [1:0] KIND_BAD    = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] term;
		logic [3:0] next;
	} prod_entry_t;

	typedef struct packed {
		logic       fire_next;
		logic       fire_term;
		logic [3:0] next;
	} match_t;

endpackage

>>> src/regular_grammar_word_acceptor.sv
// ----------------------------------------------------------------------------
// regular_grammar_word_acceptor
// Loads a right-linear grammar and checks words symbol by symbol, tracking
// the set of active nonterminals.
//
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             action lhs prod_terminal
//                                                prod_kind rhs word_symbol
//                                                last empty_word
// result    out        done, one cycle           verdict_valid accepted status
// config    in         cfg_wr_en                 cfg_wr_data (start nonterminal)
//
// Clear, add and start word: result in the cycle after the transfer, busy
// stays low, so a command may be taken every cycle.
// Feed symbol: busy through the SCAN, DRAIN and FIN states, one table entry
// read and compared per cycle in SCAN; result strobed as busy drops.
// Reset clears counts, lambda flags, active set and the start register; the
// table itself needs no clearing since counts gate every read.
// ----------------------------------------------------------------------------
module regular_grammar_word_acceptor #(
	parameter int NUM_NT   = rgwa_pkg::NUM_NONTERMINALS_DEF,
	parameter int MAX_PROD = rgwa_pkg::MAX_PRODUCTIONS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [3:0] lhs,
	input  logic [7:0] prod_terminal,
	input  logic [1:0] prod_kind,
	input  logic [3:0] rhs,
	input  logic [7:0] word_symbol,
	input  logic       last,
	input  logic       empty_word,
	output logic       done,
	output logic       verdict_valid,
	output logic       accepted,
	output logic       status
);
	import rgwa_pkg::*;

	localparam int NT_W   = $clog2(NUM_NT);
	localparam int IW     = (NT_W > 4) ? NT_W : 4;
	localparam int I_W    = (MAX_PROD > 1) ? $clog2(MAX_PROD) : 1;
	localparam int CNT_W  = $clog2(MAX_PROD + 1);
	localparam int DEPTH  = NUM_NT * MAX_PROD;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	function automatic logic in_range(input logic [3:0] x);
		return IDX_CMP_W'(x) < IDX_CMP_W'(NUM_NT);
	endfunction

	function automatic logic [NT_W-1:0] to_idx(input logic [3:0] x);
		logic [IW-1:0] w;
		w = IW'(x);
		return w[NT_W-1:0];
	endfunction

	state_t              state_q;
	logic [3:0]          start_nt_q;
	logic [CNT_W-1:0]    count_q [NUM_NT];
	logic [NUM_NT-1:0]   lambda_q;
	logic [NUM_NT-1:0]   active_q;
	logic [NUM_NT-1:0]   nxt_q;
	logic                hit_q;
	logic [7:0]          sym_q;
	logic                last_q;
	logic [NT_W-1:0]     a_q;
	logic [I_W-1:0]      i_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                done_q;
	logic                verdict_q;
	logic                accepted_q;
	logic                status_q;

	logic                take;
	logic                scanning;
	logic [NT_W-1:0]     lhs_idx;
	logic [NT_W-1:0]     start_idx;
	logic [NT_W-1:0]     cnt_idx;
	logic [CNT_W-1:0]    cnt_rd;
	logic                rd_en;
	logic                add_bad;
	logic                add_full;
	logic                add_ok;
	logic [ADDR_W-1:0]   wr_addr;
	prod_entry_t         wr_entry;
	match_t              match;

	assign take      = start && !busy;
	assign scanning  = (state_q == ST_SCAN);
	assign busy      = (state_q != ST_IDLE);
	assign lhs_idx   = to_idx(lhs);
	assign start_idx = to_idx(start_nt_q);
	assign cnt_idx   = scanning ? a_q : lhs_idx;
	assign cnt_rd    = count_q[cnt_idx];
	assign rd_en     = scanning && active_q[a_q] && (CNT_W'(i_q) < cnt_rd);

	assign add_bad  = !in_range(lhs) || ((prod_kind == KIND_NEXT) && !in_range(rhs));
	assign add_full = (cnt_rd >= CNT_W'(MAX_PROD));
	assign add_ok   = take && (action == ACT_ADD) && (prod_kind != KIND_BAD)
	                  && !add_bad && !add_full;
	assign wr_addr  = ADDR_W'(ADDR_W'(lhs_idx) * ADDR_W'(MAX_PROD)) + ADDR_W'(cnt_rd);
	assign wr_entry = '{kind: prod_kind, term: prod_terminal, next: rhs};

	rgwa_match_unit #(
		.NUM_NT   (NUM_NT),
		.MAX_PROD (MAX_PROD)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (add_ok),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (addr_q),
		.symbol   (sym_q),
		.match    (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_nt_q <= '0;
		end else if (cfg_wr_en) begin
			start_nt_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (take && (action == ACT_FEED)) begin
			sym_q  <= word_symbol;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int n = 0; n < NUM_NT; n++) begin
				count_q[n] <= '0;
			end
			lambda_q   <= '0;
			active_q   <= '0;
			nxt_q      <= '0;
			hit_q      <= 1'b0;
			a_q        <= '0;
			i_q        <= '0;
			addr_q     <= '0;
			done_q     <= 1'b0;
			verdict_q  <= 1'b0;
			accepted_q <= 1'b0;
			status_q   <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			verdict_q  <= 1'b0;
			accepted_q <= 1'b0;
			status_q   <= 1'b0;

			// accumulate compare results from the registered table read
			if (match.fire_next && in_range(match.next)) begin
				nxt_q[to_idx(match.next)] <= 1'b1;
			end
			if (match.fire_term) begin
				hit_q <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						unique case (action)
							ACT_CLEAR: begin
								for (int n = 0; n < NUM_NT; n++) begin
									count_q[n] <= '0;
								end
								lambda_q <= '0;
								active_q <= '0;
								done_q   <= 1'b1;
							end
							ACT_ADD: begin
								done_q   <= 1'b1;
								status_q <= (prod_kind != KIND_BAD) && (add_bad || add_full);
								if (add_ok) begin
									count_q[lhs_idx] <= cnt_rd + CNT_W'(1);
									if (prod_kind == KIND_LAMBDA) begin
										lambda_q[lhs_idx] <= 1'b1;
									end
								end
							end
							ACT_START: begin
								done_q   <= 1'b1;
								active_q <= '0;
								if (empty_word) begin
									verdict_q  <= 1'b1;
									accepted_q <= in_range(start_nt_q) && lambda_q[start_idx];
								end else if (in_range(start_nt_q)) begin
									active_q[start_idx] <= 1'b1;
								end
							end
							ACT_FEED: begin
								nxt_q   <= '0;
								hit_q   <= 1'b0;
								a_q     <= '0;
								i_q     <= '0;
								addr_q  <= '0;
								state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (i_q == I_W'(MAX_PROD - 1)) begin
						i_q <= '0;
						a_q <= a_q + NT_W'(1);
					end else begin
						i_q <= i_q + I_W'(1);
					end
					if (addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (last_q) begin
						verdict_q  <= 1'b1;
						accepted_q <= hit_q || |(nxt_q & lambda_q);
						active_q   <= '0;
					end else begin
						active_q <= nxt_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign verdict_valid = verdict_q;
	assign accepted      = accepted_q;
	assign status        = status_q;

endmodule

>>> src/rgwa_match_unit.sv
// ----------------------------------------------------------------------------
// rgwa_match_unit
// Production table memory with registered read and the shared symbol compare.
// ----------------------------------------------------------------------------
module rgwa_match_unit #(
	parameter int NUM_NT   = rgwa_pkg::NUM_NONTERMINALS_DEF,
	parameter int MAX_PROD = rgwa_pkg::MAX_PRODUCTIONS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [$clog2(NUM_NT*MAX_PROD)-1:0]    wr_addr,
	input  rgwa_pkg::prod_entry_t                 wr_entry,
	input  logic                                  rd_en,
	input  logic [$clog2(NUM_NT*MAX_PROD)-1:0]    rd_addr,
	input  logic [7:0]                            symbol,
	output rgwa_pkg::match_t                      match
);
	import rgwa_pkg::*;

	localparam int DEPTH = NUM_NT * MAX_PROD;

	prod_entry_t mem_q [DEPTH];
	prod_entry_t entry_s1;
	logic        en_s1;
	logic        term_eq;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		entry_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= rd_en;
		end
	end

	// lambda entries never match, even a '^' symbol
	assign term_eq         = en_s1 && (entry_s1.term == symbol);
	assign match.fire_next = term_eq && (entry_s1.kind == KIND_NEXT);
	assign match.fire_term = term_eq && (entry_s1.kind == KIND_TERM);
	assign match.next      = entry_s1.next;

endmodule

>>> src/rgwa_checker.sv
// ----------------------------------------------------------------------------
// rgwa_checker
// Port-level checks on the word acceptor's command and result behavior.
// ----------------------------------------------------------------------------
module rgwa_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic verdict_valid,
	input logic accepted,
	input logic status
);

	// a taken command either answers next cycle or starts a scan
	a_take_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("command transfer neither answered nor started a scan");

	// end of a scan always delivers its result
	a_scan_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan finished without a result");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	a_fields_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!accepted || verdict_valid) && !(verdict_valid && status))
		else $error("inconsistent result fields");

endmodule

bind regular_grammar_word_acceptor rgwa_checker u_rgwa_checker (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for regular_grammar_word_acceptor. Loads random
// right-linear grammars, feeds well-formed and broken words through the
// command port and compares every result strobe against a behavioral
// predictor held in a scoreboard. The start nonterminal is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rgwa_pkg::*;

	localparam int NT          = NUM_NONTERMINALS_DEF;
	localparam int MP          = MAX_PRODUCTIONS_DEF;
	localparam int ITEM_TARGET = 1600;
	localparam int FEED_CYCLES = NT * MP + 2;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] lhs;
		logic [7:0] prod_terminal;
		logic [1:0] prod_kind;
		logic [3:0] rhs;
		logic [7:0] word_symbol;
		logic       last;
		logic       empty_word;
	} command_t;

	typedef struct packed {
		logic verdict_valid;
		logic accepted;
		logic status;
	} verdict_t;

	class grammar_scoreboard;
		prod_entry_t   rules[NT][MP];
		int unsigned   rule_cnt[NT];
		logic [NT-1:0] lambda_nt;
		logic [NT-1:0] live_nt;
		logic [3:0]    start_nt;
		verdict_t      expected_q[$];
		int            errors;
		int            verdicts;
		int            accepts;
		int            refusals;

		function new();
			foreach (rule_cnt[i]) rule_cnt[i] = 0;
			lambda_nt = '0;
			live_nt   = '0;
			start_nt  = '0;
			errors    = 0;
			verdicts  = 0;
			accepts   = 0;
			refusals  = 0;
		endfunction

		function logic [NT-1:0] nt_bit(int unsigned idx);
			logic [NT-1:0] b;
			b = '0;
			if (idx < NT)
				b[idx] = 1'b1;
			return b;
		endfunction

		// work out the result of one accepted command and queue it
		function void note_command(command_t c);
			verdict_t      r;
			logic [NT-1:0] nxt;
			logic          hit;
			int unsigned   slot;
			r   = '0;
			nxt = '0;
			hit = 1'b0;
			case (c.action)
				ACT_CLEAR: begin
					foreach (rule_cnt[i]) rule_cnt[i] = 0;
					lambda_nt = '0;
					live_nt   = '0;
				end
				ACT_ADD: begin
					if (c.prod_kind != KIND_BAD) begin
						if (c.lhs >= NT || (c.prod_kind == KIND_NEXT && c.rhs >= NT)) begin
							r.status = 1'b1;
						end else if (rule_cnt[c.lhs] >= MP) begin
							r.status = 1'b1;
						end else begin
							slot = rule_cnt[c.lhs];
							rules[c.lhs][slot].kind = c.prod_kind;
							rules[c.lhs][slot].term = c.prod_terminal;
							rules[c.lhs][slot].next = c.rhs;
							rule_cnt[c.lhs]++;
							if (c.prod_kind == KIND_LAMBDA)
								lambda_nt |= nt_bit(c.lhs);
						end
					end
				end
				ACT_START: begin
					live_nt = nt_bit(start_nt);
					if (c.empty_word) begin
						r.verdict_valid = 1'b1;
						r.accepted      = |(live_nt & lambda_nt);
						live_nt         = '0;
					end
				end
				default: begin
					// one step of the subset walk; lambda entries never match a symbol
					for (int a = 0; a < NT; a++) begin
						if (live_nt[a]) begin
							for (int i = 0; i < rule_cnt[a] && i < MP; i++) begin
								if (rules[a][i].term == c.word_symbol) begin
									if (rules[a][i].kind == KIND_NEXT)
										nxt |= nt_bit(rules[a][i].next);
									else if (rules[a][i].kind == KIND_TERM)
										hit = 1'b1;
								end
							end
						end
					end
					if (c.last) begin
						r.verdict_valid = 1'b1;
						r.accepted      = hit || |(nxt & lambda_nt);
						live_nt         = '0;
					end else begin
						live_nt = nxt;
					end
				end
			endcase
			expected_q = {expected_q, r};
		endfunction

		function void check_result(logic v, logic a, logic s);
			verdict_t e;
			if (expected_q.size() == 0) begin
				$error("result with no command pending: verdict_valid=%0b accepted=%0b status=%0b",
					v, a, s);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (v !== e.verdict_valid) begin
				$error("verdict_valid: expected %0b, got %0b", e.verdict_valid, v);
				errors++;
			end
			if (a !== e.accepted) begin
				$error("accepted: expected %0b, got %0b", e.accepted, a);
				errors++;
			end
			if (s !== e.status) begin
				$error("status: expected %0b, got %0b", e.status, s);
				errors++;
			end
			if (e.verdict_valid)
				verdicts++;
			if (e.accepted)
				accepts++;
			if (e.status)
				refusals++;
		endfunction
	endclass

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       cfg_wr_en     = 1'b0;
	logic [3:0] cfg_wr_data   = '0;
	logic       start         = 1'b0;
	logic       busy;
	logic [1:0] action        = ACT_CLEAR;
	logic [3:0] lhs           = '0;
	logic [7:0] prod_terminal = '0;
	logic [1:0] prod_kind     = KIND_NEXT;
	logic [3:0] rhs           = '0;
	logic [7:0] word_symbol   = '0;
	logic       last          = 1'b0;
	logic       empty_word    = 1'b0;
	logic       done;
	logic       verdict_valid;
	logic       accepted;
	logic       status;

	grammar_scoreboard sb = new();

	int         items_sent  = 0;
	int         start_moves = 0;
	int         idle_pct    = 0;
	logic [3:0] cur_start   = '0;
	logic [3:0] nt_pool[4];
	logic [7:0] sym_pool[4];

	regular_grammar_word_acceptor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.lhs          (lhs),
		.prod_terminal(prod_terminal),
		.prod_kind    (prod_kind),
		.rhs          (rhs),
		.word_symbol  (word_symbol),
		.last         (last),
		.empty_word   (empty_word),
		.done         (done),
		.verdict_valid(verdict_valid),
		.accepted     (accepted),
		.status       (status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(verdict_valid, accepted, status);
	end

	// every field random; the do_* tasks overwrite what matters
	function automatic command_t filler();
		command_t c;
		c.action        = 2'($urandom_range(0, 3));
		c.lhs           = 4'($urandom_range(0, 15));
		c.prod_terminal = 8'($urandom_range(0, 255));
		c.prod_kind     = 2'($urandom_range(0, 3));
		c.rhs           = 4'($urandom_range(0, 15));
		c.word_symbol   = 8'($urandom_range(0, 255));
		c.last          = 1'($urandom_range(0, 1));
		c.empty_word    = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic logic [3:0] pick_nt();
		if ($urandom_range(0, 9) == 0)
			return 4'($urandom_range(0, 15));
		return nt_pool[$urandom_range(0, 3)];
	endfunction

	function automatic logic [7:0] pick_sym();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return sym_pool[$urandom_range(0, 3)];
	endfunction

	// caller sits at a falling edge; returns at the falling edge after the transfer once busy is low
	task automatic send(input command_t c);
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		action        = c.action;
		lhs           = c.lhs;
		prod_terminal = c.prod_terminal;
		prod_kind     = c.prod_kind;
		rhs           = c.rhs;
		word_symbol   = c.word_symbol;
		last          = c.last;
		empty_word    = c.empty_word;
		start         = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(c);
		if (!(c.action == ACT_ADD && c.prod_kind == KIND_BAD))
			items_sent++;
		@(negedge clk);
	endtask

	task automatic do_clear();
		command_t c;
		c        = filler();
		c.action = ACT_CLEAR;
		send(c);
	endtask

	task automatic do_add(input logic [3:0] l, input logic [7:0] t, input logic [1:0] k,
		input logic [3:0] r);
		command_t c;
		c               = filler();
		c.action        = ACT_ADD;
		c.lhs           = l;
		c.prod_terminal = t;
		c.prod_kind     = k;
		c.rhs           = r;
		send(c);
	endtask

	task automatic do_start(input logic e);
		command_t c;
		c            = filler();
		c.action     = ACT_START;
		c.empty_word = e;
		send(c);
	endtask

	task automatic do_feed(input logic [7:0] s, input logic l);
		command_t c;
		c             = filler();
		c.action      = ACT_FEED;
		c.word_symbol = s;
		c.last        = l;
		send(c);
	endtask

	task automatic drain();
		start = 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_start(input logic [3:0] v);
		drain();
		cfg_wr_data = v;
		cfg_wr_en   = 1'b1;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		sb.start_nt = v;
		start_moves++;
	endtask

	task automatic add_random_rule();
		int         k;
		logic [1:0] kind;
		k = $urandom_range(0, 99);
		if (k < 55)
			kind = KIND_NEXT;
		else if (k < 80)
			kind = KIND_TERM;
		else if (k < 97)
			kind = KIND_LAMBDA;
		else
			kind = KIND_BAD;
		do_add(pick_nt(), pick_sym(), kind, pick_nt());
	endtask

	// fresh grammar over a few nonterminals and symbols, then a run of words
	task automatic run_episode(input int n_words);
		int         sel;
		int         len;
		logic       broken;
		logic [3:0] victim;
		nt_pool[0] = cur_start;
		for (int i = 1; i < 4; i++)
			nt_pool[i] = 4'($urandom_range(0, 15));
		for (int i = 0; i < 4; i++)
			sym_pool[i] = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0: sym_pool[0] = 8'h00;
			1: sym_pool[0] = 8'hFF;
			2: sym_pool[0] = "^";
			default: ;
		endcase
		do_clear();
		repeat ($urandom_range(3, 20))
			add_random_rule();
		if ($urandom_range(0, 4) == 0) begin
			victim = pick_nt();
			repeat (MP + 2)
				do_add(victim, pick_sym(), 2'($urandom_range(0, 2)), pick_nt());
		end
		repeat (n_words) begin
			sel = $urandom_range(1, 100);
			if (sel <= 8) begin
				send(filler());
			end else if (sel <= 14) begin
				add_random_rule();
			end else if (sel <= 16) begin
				drain();
			end else begin
				len    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
				broken = ($urandom_range(0, 19) == 0);
				// a broken word never raises last and may also skip the start
				if (!(broken && $urandom_range(0, 1) == 0))
					do_start(len == 0);
				for (int k = 0; k < len; k++)
					do_feed(pick_sym(), (k == len - 1) && !broken);
			end
		end
	endtask

	initial begin
		int p;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: one small grammar with start 0 from reset
		do_clear();
		do_add(4'd0, "a", KIND_NEXT, 4'd1);
		do_add(4'd1, "b", KIND_TERM, 4'd0);
		do_add(4'd1, "^", KIND_LAMBDA, 4'd0);
		do_add(4'd15, 8'hFF, KIND_BAD, 4'd15);
		do_start(1'b1);
		do_start(1'b0);
		do_feed("a", 1'b0);
		do_feed("b", 1'b1);
		do_start(1'b0);
		do_feed("a", 1'b1);
		do_feed("^", 1'b1);
		do_start(1'b0);
		do_feed("a", 1'b0);
		do_feed("^", 1'b1);
		// fill one list past its end
		for (int i = 0; i < MP + 1; i++)
			do_add(4'd15, (i == 0) ? 8'h00 : 8'hFF, KIND_NEXT, 4'd15);
		do_add(4'd0, 8'h00, KIND_LAMBDA, 4'd0);
		do_start(1'b1);

		p = 0;
		while (items_sent < ITEM_TARGET) begin
			cur_start = (p == 0) ? 4'd15 : (p == 1) ? 4'd0 : 4'($urandom_range(0, 15));
			write_start(cur_start);
			repeat (3) begin
				if (items_sent > ITEM_TARGET - 250)
					idle_pct = 0;
				else
					idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 60);
				run_episode($urandom_range(10, 30));
			end
			p++;
		end

		drain();
		repeat (FEED_CYCLES + 10) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			$error("%0d results never arrived", sb.expected_q.size());
			sb.errors++;
		end
		$display("Ran %0d commands over %0d start settings: %0d verdicts, %0d accepted,",
			items_sent, start_moves, sb.verdicts, sb.accepts);
		$display("%0d productions refused, %0d mismatches.", sb.refusals, sb.errors);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results outstanding", sb.expected_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> regular_grammar_word_acceptor.f
src/rgwa_pkg.sv
src/rgwa_match_unit.sv
src/regular_grammar_word_acceptor.sv
src/rgwa_checker.sv
tb/testbench.sv
